// File: sv/stbs_pkg.sv
// Shared request/response types and codes for the sorted table bracket search.
package stbs_pkg;

	localparam int COUNT_W  = 9;
	localparam int INDEX_W  = 8;
	localparam int SAMPLE_W = 32;

	// Request kinds
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Entry count after reset
	localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 9'd2;

	typedef struct packed {
		logic                       mode;
		logic [INDEX_W-1:0]         entry_index;
		logic signed [SAMPLE_W-1:0] sample_value;
	} stbs_req_t;

	typedef struct packed {
		logic [INDEX_W-1:0] bracket_index;
		logic               in_range;
	} stbs_rsp_t;

endpackage

// File: sv/stbs_range.sv
// Head cell: range check of a query against the first and last table entries.
module stbs_range #(
	parameter int TABLE_DEPTH = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0]        wr_addr,
	input  logic signed [VALUE_WIDTH-1:0]         wr_data,
	input  logic                                  start,
	input  logic signed [VALUE_WIDTH-1:0]         start_key,
	input  logic [$clog2(TABLE_DEPTH)-1:0]        last_idx,
	output logic                                  nxt_valid,
	output logic                                  nxt_hit,
	output logic [$clog2(TABLE_DEPTH)-1:0]        nxt_lo,
	output logic [$clog2(TABLE_DEPTH)-1:0]        nxt_hi,
	output logic signed [VALUE_WIDTH-1:0]         nxt_lo_val,
	output logic signed [VALUE_WIDTH-1:0]         nxt_key
);
	localparam int IW = $clog2(TABLE_DEPTH);

	logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
	logic signed [VALUE_WIDTH-1:0] first_q;
	logic signed [VALUE_WIDTH-1:0] last_q;
	logic signed [VALUE_WIDTH-1:0] key_q;
	logic [IW-1:0]                 last_idx_q;
	logic                          valid_q;
	logic                          hit;

	// Track a request through the head cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= start;
		end
	end

	// Write table copy, read the last entry in use
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		last_q     <= mem[last_idx];
		last_idx_q <= last_idx;
		key_q      <= start_key;
	end

	// Keep entry zero at hand
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == '0)) begin
			first_q <= wr_data;
		end
	end

	// Open the interval, or collapse it when out of range
	assign hit        = !((key_q < first_q) || (key_q > last_q));
	assign nxt_valid  = valid_q;
	assign nxt_hit    = hit;
	assign nxt_lo     = '0;
	assign nxt_hi     = hit ? last_idx_q : '0;
	assign nxt_lo_val = first_q;
	assign nxt_key    = key_q;

endmodule

// File: sv/stbs_cell.sv
// One bisection cell: reads its table copy at the midpoint and narrows the interval.
module stbs_cell #(
	parameter int TABLE_DEPTH = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [$clog2(TABLE_DEPTH)-1:0]        wr_addr,
	input  logic signed [VALUE_WIDTH-1:0]         wr_data,
	input  logic                                  cur_valid,
	input  logic                                  cur_hit,
	input  logic [$clog2(TABLE_DEPTH)-1:0]        cur_lo,
	input  logic [$clog2(TABLE_DEPTH)-1:0]        cur_hi,
	input  logic signed [VALUE_WIDTH-1:0]         cur_lo_val,
	input  logic signed [VALUE_WIDTH-1:0]         cur_key,
	output logic                                  nxt_valid,
	output logic                                  nxt_hit,
	output logic [$clog2(TABLE_DEPTH)-1:0]        nxt_lo,
	output logic [$clog2(TABLE_DEPTH)-1:0]        nxt_hi,
	output logic signed [VALUE_WIDTH-1:0]         nxt_lo_val,
	output logic signed [VALUE_WIDTH-1:0]         nxt_key
);
	localparam int IW = $clog2(TABLE_DEPTH);

	logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
	logic [IW:0]                   mid_sum;
	logic [IW-1:0]                 mid;
	logic [IW-1:0]                 span;
	logic                          done;

	logic                          valid_q;
	logic                          hit_q;
	logic [IW-1:0]                 lo_q;
	logic [IW-1:0]                 hi_q;
	logic [IW-1:0]                 mid_q;
	logic signed [VALUE_WIDTH-1:0] lo_val_q;
	logic signed [VALUE_WIDTH-1:0] key_q;
	logic signed [VALUE_WIDTH-1:0] rd_q;

	// Midpoint of the incoming interval
	assign mid_sum = {1'b0, cur_lo} + {1'b0, cur_hi};
	assign mid     = mid_sum[IW:1];

	// Advance the request marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cur_valid;
		end
	end

	// Write table copy, read at the midpoint, capture the interval
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q     <= mem[mid];
		mid_q    <= mid;
		hit_q    <= cur_hit;
		lo_q     <= cur_lo;
		hi_q     <= cur_hi;
		lo_val_q <= cur_lo_val;
		key_q    <= cur_key;
	end

	// Narrow the interval unless the bounds already touch
	assign span = hi_q - lo_q;
	assign done = (span <= IW'(1));

	always_comb begin
		nxt_lo     = lo_q;
		nxt_hi     = hi_q;
		nxt_lo_val = lo_val_q;
		if (!done) begin
			if ((key_q >= lo_val_q) && (key_q < rd_q)) begin
				nxt_hi = mid_q;
			end else begin
				nxt_lo     = mid_q;
				nxt_lo_val = rd_q;
			end
		end
	end

	assign nxt_valid = valid_q;
	assign nxt_hit   = hit_q;
	assign nxt_key   = key_q;

endmodule

// File: sv/sorted_table_bracket_search.sv
// Top level of the sorted table bracket search: range cell, bisection chain, response buffer.
//
//   channel   signals                         carries
//   request   req_valid / req_ready / req     load of one entry, or a bracket query
//   response  rsp_valid / rsp_ready / rsp     bracket index and in-range flag per query
//   config    cfg_wr_en / cfg_wr_data         entry count in use, written at once
//
// Loads do not hold off the next request. A query passes through the range cell, then
// through each bisection cell in turn, each reading its own table copy once at the
// midpoint, and its result is then registered in the output register.
// One request is in flight at a time; req_ready drops from a query's acceptance until
// its result reaches the output register.
// A finished response waits in a hold register while the output register is full, and
// req_ready stays low until it moves on. Reset clears control state only.
module sorted_table_bracket_search #(
	parameter int TABLE_DEPTH = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  stbs_pkg::stbs_req_t         req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output stbs_pkg::stbs_rsp_t         rsp,
	input  logic                        cfg_wr_en,
	input  logic [stbs_pkg::COUNT_W-1:0] cfg_wr_data
);
	import stbs_pkg::*;

	localparam int IW    = $clog2(TABLE_DEPTH);
	localparam int STEPS = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH - 1) : 1;

	logic [COUNT_W-1:0]            count_q;
	logic [31:0]                   count_ext;
	logic [31:0]                   last_ext;
	logic [IW-1:0]                 last_idx;

	logic                          accept;
	logic                          load_en;
	logic                          query_start;
	logic [IW-1:0]                 wr_addr;
	logic signed [63:0]            sample_ext;
	logic signed [VALUE_WIDTH-1:0] sample_val;

	logic                          ch_valid  [STEPS+1];
	logic                          ch_hit    [STEPS+1];
	logic [IW-1:0]                 ch_lo     [STEPS+1];
	logic [IW-1:0]                 ch_hi     [STEPS+1];
	logic signed [VALUE_WIDTH-1:0] ch_lo_val [STEPS+1];
	logic signed [VALUE_WIDTH-1:0] ch_key    [STEPS+1];

	stbs_rsp_t                     res;
	stbs_rsp_t                     out_q;
	stbs_rsp_t                     hold_q;
	logic                          out_valid_q;
	logic                          hold_valid_q;
	logic                          busy_q;
	logic                          out_free;

	// Entry count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ENTRY_COUNT_RESET;
		end else if (cfg_wr_en) begin
			count_q <= cfg_wr_data;
		end
	end

	// Clamp the count to the table and take the last index in use
	assign count_ext = 32'(count_q);
	always_comb begin
		if (count_ext < 32'd2) begin
			last_ext = 32'd1;
		end else if (count_ext > 32'(TABLE_DEPTH)) begin
			last_ext = 32'(TABLE_DEPTH - 1);
		end else begin
			last_ext = count_ext - 32'd1;
		end
	end
	assign last_idx = IW'(last_ext);

	// Decode the accepted request
	assign req_ready   = !busy_q;
	assign accept      = req_valid && req_ready;
	assign load_en     = accept && (req.mode == MODE_LOAD) &&
	                     (32'(req.entry_index) < 32'(TABLE_DEPTH));
	assign query_start = accept && (req.mode == MODE_QUERY);
	assign wr_addr     = IW'(32'(req.entry_index));
	assign sample_ext  = 64'(req.sample_value);
	assign sample_val  = sample_ext[VALUE_WIDTH-1:0];

	// Range check cell
	stbs_range #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_range (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (load_en),
		.wr_addr   (wr_addr),
		.wr_data   (sample_val),
		.start     (query_start),
		.start_key (sample_val),
		.last_idx  (last_idx),
		.nxt_valid (ch_valid[0]),
		.nxt_hit   (ch_hit[0]),
		.nxt_lo    (ch_lo[0]),
		.nxt_hi    (ch_hi[0]),
		.nxt_lo_val(ch_lo_val[0]),
		.nxt_key   (ch_key[0])
	);

	// Bisection chain, one step per cell
	for (genvar k = 0; k < STEPS; k++) begin : g_cell
		stbs_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (load_en),
			.wr_addr   (wr_addr),
			.wr_data   (sample_val),
			.cur_valid (ch_valid[k]),
			.cur_hit   (ch_hit[k]),
			.cur_lo    (ch_lo[k]),
			.cur_hi    (ch_hi[k]),
			.cur_lo_val(ch_lo_val[k]),
			.cur_key   (ch_key[k]),
			.nxt_valid (ch_valid[k+1]),
			.nxt_hit   (ch_hit[k+1]),
			.nxt_lo    (ch_lo[k+1]),
			.nxt_hi    (ch_hi[k+1]),
			.nxt_lo_val(ch_lo_val[k+1]),
			.nxt_key   (ch_key[k+1])
		);
	end

	// Form the response at the end of the chain
	assign res.bracket_index = ch_hit[STEPS] ? INDEX_W'(ch_lo[STEPS]) : '0;
	assign res.in_range      = ch_hit[STEPS];

	assign out_free = !out_valid_q || rsp_ready;

	// Response buffer and busy tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
			busy_q       <= 1'b0;
		end else begin
			if (hold_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				hold_valid_q <= 1'b0;
				busy_q       <= 1'b0;
			end else if (ch_valid[STEPS]) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
					busy_q      <= 1'b0;
				end else begin
					hold_valid_q <= 1'b1;
				end
			end else if (out_valid_q && rsp_ready) begin
				out_valid_q <= 1'b0;
			end
			if (query_start) begin
				busy_q <= 1'b1;
			end
		end
	end

	// Response payload registers
	always_ff @(posedge clk) begin
		if (hold_valid_q && out_free) begin
			out_q <= hold_q;
		end else if (ch_valid[STEPS]) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				hold_q <= res;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// File: test/tb_sorted_table_bracket_search.sv
// Testbench for the sorted table bracket search: table loads, bracket queries, entry count.
`timescale 1ns / 1ps

module tb_sorted_table_bracket_search;
	import stbs_pkg::*;

	localparam int TABLE_DEPTH   = 256;
	localparam int ITEM_TARGET   = 1850;
	localparam int SETTLE_CYCLES = 16;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int HOLD_CYCLES   = 300;
	localparam int REPORT_LIMIT  = 10;

	typedef enum int {
		STYLE_DENSE,
		STYLE_SPREAD,
		STYLE_EDGES,
		STYLE_SCRAMBLED
	} table_style_e;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                req_valid   = 1'b0;
	logic                req_ready;
	stbs_req_t           req         = '0;
	logic                rsp_valid;
	logic                rsp_ready   = 1'b0;
	stbs_rsp_t           rsp;
	logic                cfg_wr_en   = 1'b0;
	logic [COUNT_W-1:0]  cfg_wr_data = '0;

	// Scoreboard state: table and entry count as the block should hold them
	logic signed [SAMPLE_W-1:0] table_model [TABLE_DEPTH];
	logic [COUNT_W-1:0]         span_model = ENTRY_COUNT_RESET;
	stbs_rsp_t                  bracket_expect_q [$];
	int                         fault_count = 0;
	int                         items_sent  = 0;

	// Stimulus state
	logic signed [SAMPLE_W-1:0] phase_vals [TABLE_DEPTH];
	int                         burst_left  = 0;
	bit                         req_gaps_on = 1'b1;

	// Response side pacing
	logic [31:0] ready_pat   = '1;
	int          pat_left    = 0;
	logic        rsp_holding = 1'b0;
	int          rsp_hold_len = HOLD_CYCLES;
	event        rsp_hold_go;

	sorted_table_bracket_search #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_WIDTH(SAMPLE_W)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#20_000_000;
		$display("tb_sorted_table_bracket_search: errors");
		$finish;
	end

	// Bisect the modeled table for one probe value
	function automatic stbs_rsp_t bracket_of(input logic signed [SAMPLE_W-1:0] probe);
		int unsigned span;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		stbs_rsp_t   found;
		found = '0;
		span = 32'(span_model);
		if (span < 2) begin
			span = 2;
		end
		if (span > TABLE_DEPTH) begin
			span = TABLE_DEPTH;
		end
		lo = 0;
		hi = span - 1;
		if (probe < table_model[lo] || probe > table_model[hi]) begin
			return found;
		end
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (probe >= table_model[lo] && probe < table_model[mid]) begin
				hi = mid;
			end else begin
				lo = mid;
			end
		end
		found.bracket_index = lo[INDEX_W-1:0];
		found.in_range = 1'b1;
		return found;
	endfunction

	function automatic void log_fault(input string msg);
		fault_count++;
		if (fault_count <= REPORT_LIMIT) begin
			$display("%0t: %s", $time, msg);
		end
	endfunction

	// Check each response, then track config writes and accepted requests
	always @(posedge clk) begin
		stbs_rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (bracket_expect_q.size() == 0) begin
					log_fault($sformatf("response with none pending: index %0d in_range %b",
						rsp.bracket_index, rsp.in_range));
				end else begin
					want = bracket_expect_q.pop_front();
					if (rsp.bracket_index !== want.bracket_index ||
					    rsp.in_range !== want.in_range) begin
						log_fault($sformatf(
							"mismatch: index exp %0d got %0d, in_range exp %b got %b",
							want.bracket_index, rsp.bracket_index,
							want.in_range, rsp.in_range));
					end
				end
			end
			if (cfg_wr_en) begin
				span_model = cfg_wr_data;
			end
			if (req_valid && req_ready) begin
				if (req.mode == MODE_LOAD) begin
					table_model[req.entry_index] = req.sample_value;
				end else begin
					bracket_expect_q.push_back(bracket_of(req.sample_value));
				end
			end
		end
	end

	// Pace rsp_ready from a rotating pattern, forced low during a long hold
	always @(posedge clk) begin
		if (pat_left == 0) begin
			case ($urandom_range(0, 3))
				0: ready_pat = '1;
				1: ready_pat = $urandom;
				2: ready_pat = ~($urandom & $urandom);
				default: ready_pat = $urandom & $urandom;
			endcase
			pat_left = $urandom_range(16, 96);
		end
		rsp_ready <= ready_pat[0] && !rsp_holding;
		ready_pat = {ready_pat[0], ready_pat[31:1]};
		pat_left--;
	end

	// Hold the response side off for a counted stretch
	initial begin
		forever begin
			@(rsp_hold_go);
			rsp_holding <= 1'b1;
			repeat (rsp_hold_len) @(posedge clk);
			rsp_holding <= 1'b0;
		end
	end

	// Offer one request, with a random gap at the start of each burst
	task automatic send_req(input stbs_req_t item);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = req_gaps_on ? $urandom_range(0, 14) : 0;
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_load(input int idx, input logic signed [SAMPLE_W-1:0] val);
		stbs_req_t item;
		item.mode = MODE_LOAD;
		item.entry_index = idx[INDEX_W-1:0];
		item.sample_value = val;
		send_req(item);
	endtask

	task automatic send_query(input logic signed [SAMPLE_W-1:0] val);
		stbs_req_t item;
		item.mode = MODE_QUERY;
		item.entry_index = INDEX_W'($urandom_range(0, 255));
		item.sample_value = val;
		send_req(item);
	endtask

	// Drop valid and wait until every pending query has answered
	task automatic drain_requests();
		req_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (bracket_expect_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_entry_count(input logic [COUNT_W-1:0] val);
		drain_requests();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Fill phase_vals[0..n-1] in the given style
	task automatic build_table(input int n, input table_style_e style);
		longint step_max;
		longint cur;
		if (style == STYLE_DENSE) begin
			step_max = 4;
		end else begin
			step_max = 64'hFFFF_FFFF / (n + 1);
		end
		cur = -64'sd2147483648 +
			longint'($urandom_range(0, 32'(64'hFFFF_FFFF - n * step_max)));
		for (int k = 0; k < n; k++) begin
			phase_vals[k] = cur[SAMPLE_W-1:0];
			cur += longint'($urandom_range(1, 32'(step_max)));
		end
		if (style == STYLE_EDGES) begin
			phase_vals[0] = 32'sh8000_0000;
			phase_vals[n-1] = 32'sh7FFF_FFFF;
		end else if (style == STYLE_SCRAMBLED) begin
			for (int k = 0; k < n; k++) begin
				phase_vals[k] = ($urandom_range(0, 1) != 0) ? $urandom :
					$signed($urandom_range(0, 15)) - 8;
			end
		end
	endtask

	// Load phase_vals[0..n-1] in shuffled order, with stray loads and queries mixed in
	task automatic load_table(input int n);
		int order [TABLE_DEPTH];
		int j;
		int tmp;
		for (int k = 0; k < n; k++) begin
			order[k] = k;
		end
		for (int k = n - 1; k > 0; k--) begin
			j = $urandom_range(0, k);
			tmp = order[k];
			order[k] = order[j];
			order[j] = tmp;
		end
		for (int k = 0; k < n; k++) begin
			if (n < TABLE_DEPTH && $urandom_range(0, 7) == 0) begin
				send_load($urandom_range(n, TABLE_DEPTH - 1), $urandom);
			end
			if ($urandom_range(0, 9) == 0) begin
				send_query($urandom);
			end
			send_load(order[k], phase_vals[order[k]]);
		end
	endtask

	// Pick a probe near the table entries, just past either end, or anywhere
	function automatic logic signed [SAMPLE_W-1:0] pick_probe(input int n);
		int k;
		k = $urandom_range(0, n - 1);
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return phase_vals[0] - 1 - $signed($urandom_range(0, 3));
			2: return phase_vals[n-1] + 1 + $signed($urandom_range(0, 3));
			3: return phase_vals[0];
			4: return phase_vals[n-1];
			default: return phase_vals[k] + $signed($urandom_range(0, 2)) - 1;
		endcase
	endfunction

	// Two-entry table at reset count: extremes, equal ends, just outside
	task automatic test_two_entry_bounds();
		send_load(0, 32'sh8000_0000);
		send_load(1, 32'sh7FFF_FFFF);
		send_query(32'sh8000_0000);
		send_query(32'sh7FFF_FFFF);
		send_query(0);
		send_load(0, -100);
		send_load(1, 100);
		send_load(TABLE_DEPTH - 1, 32'sh5555_AAAA);
		send_query(-101);
		send_query(101);
		send_query(-100);
		send_query(100);
		send_query(32'sh8000_0000);
		send_query(32'sh7FFF_FFFF);
	endtask

	// Entry counts below two act as two
	task automatic test_count_clamp_low();
		write_entry_count(0);
		send_query(0);
		send_query(100);
		write_entry_count(1);
		send_query(-100);
		send_query(101);
		write_entry_count(ENTRY_COUNT_RESET);
		send_query(-99);
	endtask

	// Full table with both extremes; counts above the depth act as the depth
	task automatic test_full_span_table();
		build_table(TABLE_DEPTH, STYLE_EDGES);
		load_table(TABLE_DEPTH);
		write_entry_count(9'd511);
		for (int k = 0; k < 20; k++) begin
			send_query(pick_probe(TABLE_DEPTH));
		end
		write_entry_count(9'd257);
		for (int k = 0; k < 20; k++) begin
			send_query(pick_probe(TABLE_DEPTH));
		end
		write_entry_count(9'd256);
		for (int k = 0; k < 20; k++) begin
			send_query(pick_probe(TABLE_DEPTH));
		end
	endtask

	// Stall responses for a long stretch while requests keep coming, then pause
	task automatic test_output_stall();
		req_gaps_on = 1'b0;
		-> rsp_hold_go;
		for (int k = 0; k < 16; k++) begin
			send_query(pick_probe(TABLE_DEPTH));
		end
		drain_requests();
		req_gaps_on = 1'b1;
	endtask

	// Random tables and counts, then queries against each
	task automatic test_random_tables();
		int n;
		int cfg_val;
		int probes;
		int phase_no;
		table_style_e style;
		phase_no = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase_no == 0) begin
				n = 2;
			end else if (phase_no == 1) begin
				n = TABLE_DEPTH;
			end else begin
				case ($urandom_range(0, 19))
					0, 1, 2: n = $urandom_range(65, TABLE_DEPTH);
					3, 4, 5, 6, 7: n = $urandom_range(17, 64);
					default: n = $urandom_range(2, 16);
				endcase
			end
			cfg_val = n;
			if (n == 2 && $urandom_range(0, 1) != 0) begin
				cfg_val = $urandom_range(0, 2);
			end else if (n == TABLE_DEPTH && $urandom_range(0, 1) != 0) begin
				cfg_val = $urandom_range(TABLE_DEPTH, 511);
			end
			style = table_style_e'($urandom_range(0, 3));
			req_gaps_on = ($urandom_range(0, 3) != 0);
			write_entry_count(cfg_val[COUNT_W-1:0]);
			build_table(n, style);
			load_table(n);
			probes = $urandom_range(20, 50);
			for (int k = 0; k < probes; k++) begin
				send_query(pick_probe(n));
			end
			phase_no++;
		end
	endtask

	task automatic finish_run();
		int waited;
		req_valid <= 1'b0;
		waited = 0;
		while (bracket_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (bracket_expect_q.size() != 0) begin
			log_fault($sformatf("%0d responses never arrived", bracket_expect_q.size()));
		end
		if (fault_count == 0) begin
			$display("tb_sorted_table_bracket_search: clean");
		end else begin
			$display("tb_sorted_table_bracket_search: errors");
		end
		$finish;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_two_entry_bounds();
		test_count_clamp_low();
		test_full_span_table();
		test_output_stall();
		test_random_tables();
		finish_run();
	end

endmodule
